>>> rtl/mfba_pkg.sv
// Package for the max-flow augmenting-path core: field widths, register
// indexes, controller states and datapath command codes.
// No dependencies.
package mfba_pkg;

   localparam int NODE_IN_W = 6;
   localparam int CAP_IN_W  = 16;
   localparam int TOTAL_W   = 30;

   localparam logic [0:0] REG_SOURCE = 1'b0;
   localparam logic [0:0] REG_SINK   = 1'b1;

   localparam logic [NODE_IN_W-1:0] SOURCE_RESET = 6'd0;
   localparam logic [NODE_IN_W-1:0] SINK_RESET   = 6'd25;
   localparam logic [TOTAL_W-1:0]   TOTAL_MAX    = {TOTAL_W{1'b1}};

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR1,
      ST_LD_WR2,
      ST_CALC,
      ST_BFS_INIT,
      ST_DEQ,
      ST_DEQ_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_WALK_INIT,
      ST_W1_PRD,
      ST_W1_RES,
      ST_W1_MIN,
      ST_W2_INIT,
      ST_W2_PRD,
      ST_W2_RD1,
      ST_W2_WR1,
      ST_W2_WR2,
      ST_OUT
   } st_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE,
      OP_LD_RD,
      OP_LD_WR1,
      OP_LD_WR2,
      OP_CALC,
      OP_BFS_INIT,
      OP_DEQ,
      OP_SCAN_START,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_WALK_INIT,
      OP_W1_PRD,
      OP_W1_RES,
      OP_W1_MIN,
      OP_W2_INIT,
      OP_W2_PRD,
      OP_W2_RD1,
      OP_W2_WR1,
      OP_W2_WR2,
      OP_ADD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic clr_done;
      logic last;
      logic cfg_bad;
      logic q_empty;
      logic dst_found;
      logic scan_last;
      logic at_src;
      logic bn_zero;
      logic rsp_busy;
   } status_type;

endpackage

>>> rtl/max_flow_bfs_augment_core.sv
// Edmonds-Karp maximum flow core. Edges are loaded one item at a time: accept,
// then a read and two writes of the residual memory. On the item marked last
// the core checks the source and sink and, if valid, runs breadth-first
// searches from the source, examining every node as a neighbour of each node
// taken from the queue, then walks each path back from the sink, once to find
// the bottleneck and once to update it; the total flow is then offered on the
// result channel. Before the next item is accepted, and after reset, all
// 2**(2*ceil(log2 NODES)) residual memory entries, 4096 at the default size,
// are zeroed, one entry a cycle. Configuration writes are taken at any time.
module max_flow_bfs_augment_core #(
   parameter int NODES    = 64,
   parameter int CAP_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // node_from[5:0], node_to[11:6], edge_capacity[27:12]
   input  logic        req_tlast,   // last_edge
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // max_flow[29:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   mfba_pkg::op_type     op;
   mfba_pkg::status_type stat;

   mfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   mfba_dp #(
      .NODES    (NODES),
      .CAP_BITS (CAP_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

>>> rtl/mfba_ctrl.sv
// Sequencer for the max-flow core: loading, searches, path walks and clearing.
// Depends on mfba_pkg; drives the datapath mfba_dp through one command code.
module mfba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mfba_pkg::status_type stat,
   output mfba_pkg::op_type   op
);

   mfba_pkg::st_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = mfba_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         mfba_pkg::ST_CLEAR: begin
            op = mfba_pkg::OP_CLEAR;
            if (stat.clr_done) state_in = mfba_pkg::ST_IDLE;
         end
         mfba_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = mfba_pkg::OP_TAKE;
               state_in = mfba_pkg::ST_LD_RD;
            end
         end
         mfba_pkg::ST_LD_RD: begin
            op       = mfba_pkg::OP_LD_RD;
            state_in = mfba_pkg::ST_LD_WR1;
         end
         mfba_pkg::ST_LD_WR1: begin
            op       = mfba_pkg::OP_LD_WR1;
            state_in = mfba_pkg::ST_LD_WR2;
         end
         mfba_pkg::ST_LD_WR2: begin
            op       = mfba_pkg::OP_LD_WR2;
            state_in = stat.last ? mfba_pkg::ST_CALC : mfba_pkg::ST_IDLE;
         end
         mfba_pkg::ST_CALC: begin
            op       = mfba_pkg::OP_CALC;
            state_in = stat.cfg_bad ? mfba_pkg::ST_OUT : mfba_pkg::ST_BFS_INIT;
         end
         mfba_pkg::ST_BFS_INIT: begin
            op       = mfba_pkg::OP_BFS_INIT;
            state_in = mfba_pkg::ST_DEQ;
         end
         mfba_pkg::ST_DEQ: begin
            if (stat.dst_found) begin
               state_in = mfba_pkg::ST_WALK_INIT;
            end else if (stat.q_empty) begin
               state_in = mfba_pkg::ST_OUT;
            end else begin
               op       = mfba_pkg::OP_DEQ;
               state_in = mfba_pkg::ST_DEQ_WAIT;
            end
         end
         mfba_pkg::ST_DEQ_WAIT: begin
            op       = mfba_pkg::OP_SCAN_START;
            state_in = mfba_pkg::ST_SCAN_RD;
         end
         mfba_pkg::ST_SCAN_RD: begin
            op       = mfba_pkg::OP_SCAN_RD;
            state_in = mfba_pkg::ST_SCAN_CHK;
         end
         mfba_pkg::ST_SCAN_CHK: begin
            op       = mfba_pkg::OP_SCAN_CHK;
            state_in = stat.scan_last ? mfba_pkg::ST_DEQ : mfba_pkg::ST_SCAN_RD;
         end
         mfba_pkg::ST_WALK_INIT: begin
            op       = mfba_pkg::OP_WALK_INIT;
            state_in = mfba_pkg::ST_W1_PRD;
         end
         mfba_pkg::ST_W1_PRD: begin
            if (stat.at_src) begin
               state_in = mfba_pkg::ST_W2_INIT;
            end else begin
               op       = mfba_pkg::OP_W1_PRD;
               state_in = mfba_pkg::ST_W1_RES;
            end
         end
         mfba_pkg::ST_W1_RES: begin
            op       = mfba_pkg::OP_W1_RES;
            state_in = mfba_pkg::ST_W1_MIN;
         end
         mfba_pkg::ST_W1_MIN: begin
            op       = mfba_pkg::OP_W1_MIN;
            state_in = mfba_pkg::ST_W1_PRD;
         end
         mfba_pkg::ST_W2_INIT: begin
            if (stat.bn_zero) begin
               state_in = mfba_pkg::ST_OUT;
            end else begin
               op       = mfba_pkg::OP_W2_INIT;
               state_in = mfba_pkg::ST_W2_PRD;
            end
         end
         mfba_pkg::ST_W2_PRD: begin
            if (stat.at_src) begin
               op       = mfba_pkg::OP_ADD;
               state_in = mfba_pkg::ST_BFS_INIT;
            end else begin
               op       = mfba_pkg::OP_W2_PRD;
               state_in = mfba_pkg::ST_W2_RD1;
            end
         end
         mfba_pkg::ST_W2_RD1: begin
            op       = mfba_pkg::OP_W2_RD1;
            state_in = mfba_pkg::ST_W2_WR1;
         end
         mfba_pkg::ST_W2_WR1: begin
            op       = mfba_pkg::OP_W2_WR1;
            state_in = mfba_pkg::ST_W2_WR2;
         end
         mfba_pkg::ST_W2_WR2: begin
            op       = mfba_pkg::OP_W2_WR2;
            state_in = mfba_pkg::ST_W2_PRD;
         end
         mfba_pkg::ST_OUT: begin
            if (!stat.rsp_busy) begin
               op       = mfba_pkg::OP_EMIT;
               state_in = mfba_pkg::ST_CLEAR;
            end
         end
         default: state_in = mfba_pkg::ST_CLEAR;
      endcase
   end

endmodule

>>> rtl/mfba_dp.sv
// Datapath of the max-flow core: residual memory, search queue, predecessor
// memory, visited bits, path walk registers and result register.
// Depends on mfba_pkg; commanded by mfba_ctrl.
module mfba_dp #(
   parameter int NODES    = 64,
   parameter int CAP_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  mfba_pkg::op_type    op,
   output mfba_pkg::status_type stat,
   input  logic [31:0]         req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [5:0]          csr_wdata
);

   localparam int NW     = $clog2(NODES);
   localparam int AW     = 2 * NW;
   localparam int RW     = CAP_BITS + 1;
   localparam int LD_W   = ((CAP_BITS > mfba_pkg::CAP_IN_W) ? CAP_BITS : mfba_pkg::CAP_IN_W) + 1;
   localparam int SUM_W  = ((RW > mfba_pkg::TOTAL_W) ? RW : mfba_pkg::TOTAL_W) + 1;
   localparam logic [LD_W-1:0] CAP_MAX = LD_W'((64'd1 << CAP_BITS) - 64'd1);

   // Residual capacity, cap(u,v) - flow(u,v), addressed by {u, v}.
   logic [RW-1:0] res_mem [2**AW];
   logic [NW-1:0] pred_mem [NODES];
   logic [NW-1:0] q_mem [NODES];

   logic [RW-1:0] res_rd_ff;
   logic [NW-1:0] pred_rd_ff, q_rd_ff;
   logic          res_we, pred_we, q_we;
   logic [AW-1:0] res_waddr, res_raddr;
   logic [RW-1:0] res_wdata;
   logic [NW-1:0] pred_waddr, pred_wdata, pred_raddr, q_waddr, q_wdata, q_raddr;

   logic [5:0]    src_ff, dst_ff;
   logic [AW-1:0] clr_ff;
   logic [NODES-1:0] seen_ff;
   logic [NW:0]   head_ff, tail_ff;
   logic [mfba_pkg::TOTAL_W-1:0] total_ff, rsp_data_ff;
   logic          rsp_valid_ff;

   logic [5:0]    a_ff, b_ff;
   logic [mfba_pkg::CAP_IN_W-1:0] c_ff;
   logic          last_ff;
   logic [RW-1:0] ld_val_ff;
   logic [NW-1:0] u_ff, v_ff, k_ff, p_ff;
   logic [RW-1:0] bn_ff;

   logic          edge_ok, cfg_bad, found;
   logic [LD_W-1:0] ld_sum;
   logic [RW-1:0] ld_sat;
   logic [SUM_W-1:0] tot_sum;
   logic [NW-1:0] src_i, dst_i, a_i, b_i;

   assign src_i   = NW'(src_ff);
   assign dst_i   = NW'(dst_ff);
   assign a_i     = NW'(a_ff);
   assign b_i     = NW'(b_ff);
   assign edge_ok = (32'(a_ff) < NODES) && (32'(b_ff) < NODES);
   assign cfg_bad = (32'(src_ff) >= NODES) || (32'(dst_ff) >= NODES) || (src_ff == dst_ff);
   assign ld_sum  = LD_W'(res_rd_ff) + LD_W'(c_ff);
   assign ld_sat  = (ld_sum > CAP_MAX) ? RW'(CAP_MAX) : RW'(ld_sum);
   assign found   = !seen_ff[v_ff] && (res_rd_ff != '0);
   assign tot_sum = SUM_W'(total_ff) + SUM_W'(bn_ff);

   always_comb begin
      res_we     = 1'b0;
      res_waddr  = clr_ff;
      res_wdata  = '0;
      res_raddr  = {a_i, b_i};
      pred_we    = 1'b0;
      pred_waddr = v_ff;
      pred_wdata = u_ff;
      pred_raddr = k_ff;
      q_we       = 1'b0;
      q_waddr    = tail_ff[NW-1:0];
      q_wdata    = v_ff;
      q_raddr    = head_ff[NW-1:0];
      case (op)
         mfba_pkg::OP_CLEAR: res_we = 1'b1;
         mfba_pkg::OP_LD_WR1: begin
            res_we    = edge_ok;
            res_waddr = {a_i, b_i};
            res_wdata = ld_sat;
         end
         mfba_pkg::OP_LD_WR2: begin
            res_we    = edge_ok;
            res_waddr = {b_i, a_i};
            res_wdata = ld_val_ff;
         end
         mfba_pkg::OP_BFS_INIT: begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = src_i;
         end
         mfba_pkg::OP_SCAN_RD: res_raddr = {u_ff, v_ff};
         mfba_pkg::OP_SCAN_CHK: begin
            pred_we = found;
            q_we    = found && (tail_ff < (NW+1)'(NODES));
         end
         mfba_pkg::OP_W1_RES: res_raddr = {pred_rd_ff, k_ff};
         mfba_pkg::OP_W2_RD1: res_raddr = {pred_rd_ff, k_ff};
         mfba_pkg::OP_W2_WR1: begin
            res_we    = 1'b1;
            res_waddr = {p_ff, k_ff};
            res_wdata = res_rd_ff - bn_ff;
            res_raddr = {k_ff, p_ff};
         end
         mfba_pkg::OP_W2_WR2: begin
            res_we    = 1'b1;
            res_waddr = {k_ff, p_ff};
            res_wdata = res_rd_ff + bn_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_waddr] <= res_wdata;
      res_rd_ff <= res_mem[res_raddr];
   end

   always_ff @(posedge clock) begin
      if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
      pred_rd_ff <= pred_mem[pred_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[q_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff       <= mfba_pkg::SOURCE_RESET;
         dst_ff       <= mfba_pkg::SINK_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == mfba_pkg::REG_SOURCE) src_ff <= csr_wdata;
            if (csr_index == mfba_pkg::REG_SINK)   dst_ff <= csr_wdata;
         end
         if (op == mfba_pkg::OP_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (op)
            mfba_pkg::OP_CALC: total_ff <= '0;
            mfba_pkg::OP_ADD: begin
               total_ff <= (tot_sum > SUM_W'(mfba_pkg::TOTAL_MAX)) ?
                           mfba_pkg::TOTAL_MAX : mfba_pkg::TOTAL_W'(tot_sum);
            end
            mfba_pkg::OP_EMIT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // Item, search and walk registers.
   always_ff @(posedge clock) begin
      case (op)
         mfba_pkg::OP_TAKE: begin
            a_ff    <= req_tdata[5:0];
            b_ff    <= req_tdata[11:6];
            c_ff    <= req_tdata[27:12];
            last_ff <= req_tlast;
         end
         mfba_pkg::OP_LD_WR1: ld_val_ff <= ld_sat;
         mfba_pkg::OP_BFS_INIT: begin
            // Only the source starts out as visited.
            seen_ff <= NODES'(1) << src_i;
            head_ff <= '0;
            tail_ff <= (NW+1)'(1);
         end
         mfba_pkg::OP_DEQ: head_ff <= head_ff + 1'b1;
         mfba_pkg::OP_SCAN_START: begin
            u_ff <= q_rd_ff;
            v_ff <= '0;
         end
         mfba_pkg::OP_SCAN_CHK: begin
            if (found) begin
               seen_ff[v_ff] <= 1'b1;
               if (tail_ff < (NW+1)'(NODES)) tail_ff <= tail_ff + 1'b1;
            end
            v_ff <= v_ff + 1'b1;
         end
         mfba_pkg::OP_WALK_INIT: begin
            k_ff  <= dst_i;
            bn_ff <= '1;
         end
         mfba_pkg::OP_W1_RES: p_ff <= pred_rd_ff;
         mfba_pkg::OP_W1_MIN: begin
            if (res_rd_ff < bn_ff) bn_ff <= res_rd_ff;
            k_ff <= p_ff;
         end
         mfba_pkg::OP_W2_INIT: k_ff <= dst_i;
         mfba_pkg::OP_W2_RD1: p_ff <= pred_rd_ff;
         mfba_pkg::OP_W2_WR2: k_ff <= p_ff;
         mfba_pkg::OP_EMIT: rsp_data_ff <= total_ff;
         default: ;
      endcase
   end

   assign stat.clr_done  = (clr_ff == '1);
   assign stat.last      = last_ff;
   assign stat.cfg_bad   = cfg_bad;
   assign stat.q_empty   = (head_ff == tail_ff);
   assign stat.dst_found = seen_ff[dst_i];
   assign stat.scan_last = (v_ff == NW'(NODES - 1));
   assign stat.at_src    = (k_ff == src_i);
   assign stat.bn_zero   = (bn_ff == '0);
   assign stat.rsp_busy  = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

>>> rtl/mfba_chk.sv
// Port-level checks for the max-flow core, bound to the top level.
// Depends only on the ports of max_flow_bfs_augment_core.
module mfba_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // No result survives a reset.
   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Loading an edge occupies the residual memory for the following cycles.
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted on consecutive cycles");

   // The flow total never uses the padding bits.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("padding bits of the result set");

endmodule

bind max_flow_bfs_augment_core mfba_chk u_mfba_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
